@@ hw/rtl/xymag_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xymag_pkg: shared types and constants
// Field widths, parameter defaults, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package xymag_pkg;

  // fixed result and time field widths
  localparam int MAG_W  = 16;
  localparam int RATE_W = 26;
  localparam int DT_W   = 16;

  // parameter defaults
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int RATE_FRAC_BITS_DEF = 10;

  // item function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_SQRT,
    ST_DIFF,
    ST_DIV,
    ST_UPD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic sq_x;       // square |x|
    logic sq_y;       // square |y|, keep x^2
    logic sum_init;   // form radicand, start square root
    logic sqrt_step;  // one root bit
    logic diff_init;  // |mag - prev|, start divide
    logic div_step;   // one quotient bit
    logic load_out;   // update state, load result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;   // captured item is a clear
  } sts_t;

endpackage : xymag_pkg
`default_nettype wire

@@ hw/rtl/xy_magnitude_rate_peak_tracker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xy_magnitude_rate_peak_tracker: XY magnitude, change rate and peak hold
// Flow: a sample item is squared, summed, passed through the bit-serial square
//   root and the bit-serial divider, then committed; a clear goes to the commit.
// One item at a time: in_stall stays high until the result is committed.
// Reset: synchronous, active low; clears peaks and previous magnitude.
// ----------------------------------------------------------------------------
module xy_magnitude_rate_peak_tracker #(
  parameter int SAMPLE_BITS    = xymag_pkg::SAMPLE_BITS_DEF,
  parameter int RATE_FRAC_BITS = xymag_pkg::RATE_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_func,
  input  wire logic signed [SAMPLE_BITS-1:0]  in_accel_x,
  input  wire logic signed [SAMPLE_BITS-1:0]  in_accel_y,
  input  wire logic [xymag_pkg::DT_W-1:0]     in_delta_time,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [xymag_pkg::MAG_W-1:0]         out_magnitude,
  output logic [xymag_pkg::RATE_W-1:0]        out_change_rate,
  output logic [xymag_pkg::MAG_W-1:0]         out_peak_magnitude,
  output logic [xymag_pkg::RATE_W-1:0]        out_peak_rate,
  output logic                                out_new_peak_magnitude,
  output logic                                out_new_peak_rate
);
  import xymag_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  xymag_ctrl #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .RATE_FRAC_BITS (RATE_FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // arithmetic and tracker state
  xymag_dpath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .RATE_FRAC_BITS (RATE_FRAC_BITS)
  ) u_dpath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_func                (in_func),
    .in_accel_x             (in_accel_x),
    .in_accel_y             (in_accel_y),
    .in_delta_time          (in_delta_time),
    .out_magnitude          (out_magnitude),
    .out_change_rate        (out_change_rate),
    .out_peak_magnitude     (out_peak_magnitude),
    .out_peak_rate          (out_peak_rate),
    .out_new_peak_magnitude (out_new_peak_magnitude),
    .out_new_peak_rate      (out_new_peak_rate)
  );

endmodule : xy_magnitude_rate_peak_tracker
`default_nettype wire

@@ hw/rtl/xymag_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xymag_ctrl: sequencing controller
// Walks each sample item through square, sum, bit-serial root and bit-serial
// divide, sends a clear straight to the update, and owns the result valid flag.
// ----------------------------------------------------------------------------
module xymag_ctrl #(
  parameter int SAMPLE_BITS    = xymag_pkg::SAMPLE_BITS_DEF,
  parameter int RATE_FRAC_BITS = xymag_pkg::RATE_FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output xymag_pkg::cmd_t    cmd,
  input  wire xymag_pkg::sts_t sts
);
  import xymag_pkg::*;

  localparam int SQRT_STEPS = SAMPLE_BITS + 1;
  localparam int DIV_STEPS  = MAG_W + RATE_FRAC_BITS;
  localparam int MAX_STEPS  = (SQRT_STEPS > DIV_STEPS) ? SQRT_STEPS : DIV_STEPS;
  localparam int CNT_W      = $clog2(MAX_STEPS);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;

  // result slot is free when empty or being taken now
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != ST_IDLE);

  // state, counter and valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQX;
        end
      end
      ST_SQX: begin
        if (sts.is_clear) begin
          state_nxt = ST_UPD;
        end else begin
          cmd.sq_x  = 1'b1;
          state_nxt = ST_SQY;
        end
      end
      ST_SQY: begin
        cmd.sq_y  = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_init = 1'b1;
        cnt_nxt      = CNT_W'(SQRT_STEPS - 1);
        state_nxt    = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DIFF;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_DIFF: begin
        cmd.diff_init = 1'b1;
        cnt_nxt       = CNT_W'(DIV_STEPS - 1);
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_UPD;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_UPD: begin
        // wait for the result slot, then commit
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule : xymag_ctrl
`default_nettype wire

@@ hw/rtl/xymag_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xymag_dpath: magnitude, rate and peak datapath
// Shared squarer, restoring bit-serial square root and divider, tracker
// state and the result register.
// ----------------------------------------------------------------------------
module xymag_dpath #(
  parameter int SAMPLE_BITS    = xymag_pkg::SAMPLE_BITS_DEF,
  parameter int RATE_FRAC_BITS = xymag_pkg::RATE_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire xymag_pkg::cmd_t                cmd,
  output xymag_pkg::sts_t                     sts,
  input  wire logic                           in_func,
  input  wire logic signed [SAMPLE_BITS-1:0]  in_accel_x,
  input  wire logic signed [SAMPLE_BITS-1:0]  in_accel_y,
  input  wire logic [xymag_pkg::DT_W-1:0]     in_delta_time,
  output logic [xymag_pkg::MAG_W-1:0]         out_magnitude,
  output logic [xymag_pkg::RATE_W-1:0]        out_change_rate,
  output logic [xymag_pkg::MAG_W-1:0]         out_peak_magnitude,
  output logic [xymag_pkg::RATE_W-1:0]        out_peak_rate,
  output logic                                out_new_peak_magnitude,
  output logic                                out_new_peak_rate
);
  import xymag_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int PW    = 2 * SB;          // square width
  localparam int ROOTW = SB + 1;          // root width
  localparam int RADW  = 2 * ROOTW;       // radicand width
  localparam int REMW  = SB + 4;          // root remainder width
  localparam int DVW   = MAG_W + RATE_FRAC_BITS;  // dividend width

  // captured item
  logic              func_r;
  logic [SB-1:0]     ax_r, ay_r;
  logic [DT_W-1:0]   dt_r;

  // arithmetic registers
  logic [PW-1:0]     prod_r, sumsq_r;
  logic [RADW-1:0]   rad_r;
  logic [REMW-1:0]   rem_r;
  logic [ROOTW-1:0]  root_r;
  logic [MAG_W-1:0]  mag_r;
  logic [DVW-1:0]    dvd_r;
  logic [DT_W-1:0]   drem_r;

  // tracker state
  logic              prev_valid_r;
  logic [MAG_W-1:0]  prev_mag_r;
  logic [MAG_W-1:0]  peak_mag_r;
  logic [RATE_W-1:0] peak_rate_r;

  // combinational helpers
  logic [SB-1:0]     ax_abs, ay_abs, mul_a;
  logic [PW:0]       sum_w;
  logic [REMW-1:0]   rem_sh, trial;
  logic              root_bit;
  logic [MAG_W-1:0]  mag_w, diff_w;
  logic [DT_W:0]     drem_sh;
  logic              q_bit;
  logic [RATE_W-1:0] rate_w;
  logic              up_mag, up_rate;

  assign sts.is_clear = (func_r == FUNC_CLEAR);

  // absolute values and shared squarer operand
  assign ax_abs = ax_r[SB-1] ? SB'(~ax_r + SB'(1)) : ax_r;
  assign ay_abs = ay_r[SB-1] ? SB'(~ay_r + SB'(1)) : ay_r;
  assign mul_a  = cmd.sq_y ? ay_abs : ax_abs;
  assign sum_w  = {1'b0, sumsq_r} + {1'b0, prod_r};

  // root step: bring down two radicand bits, try (root << 2) | 1
  assign rem_sh   = {rem_r[REMW-3:0], rad_r[RADW-1 -: 2]};
  assign trial    = REMW'({root_r, 2'b01});
  assign root_bit = (rem_sh >= trial);

  // magnitude from the finished root and its change from the previous one
  assign mag_w  = MAG_W'(root_r);
  assign diff_w = (mag_w >= prev_mag_r) ? (mag_w - prev_mag_r) : (prev_mag_r - mag_w);

  // divide step: bring down one dividend bit
  assign drem_sh = {drem_r, dvd_r[DVW-1]};
  assign q_bit   = (drem_sh >= {1'b0, dt_r});

  // rate is zero without a previous magnitude or with zero elapsed time
  assign rate_w  = (prev_valid_r && (dt_r != '0)) ? RATE_W'(dvd_r) : '0;
  assign up_mag  = (mag_r > peak_mag_r);
  assign up_rate = (rate_w > peak_rate_r);

  // item capture and arithmetic
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      ax_r   <= in_accel_x;
      ay_r   <= in_accel_y;
      dt_r   <= in_delta_time;
    end
    if (cmd.sq_x || cmd.sq_y) begin
      prod_r <= PW'(mul_a) * PW'(mul_a);
    end
    if (cmd.sq_y) begin
      sumsq_r <= prod_r;
    end
    if (cmd.sum_init) begin
      rad_r  <= RADW'(sum_w);
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.sqrt_step) begin
      rad_r  <= {rad_r[RADW-3:0], 2'b00};
      rem_r  <= root_bit ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOTW-2:0], root_bit};
    end
    if (cmd.diff_init) begin
      mag_r  <= mag_w;
      dvd_r  <= DVW'(diff_w) << RATE_FRAC_BITS;
      drem_r <= '0;
    end
    if (cmd.div_step) begin
      drem_r <= q_bit ? DT_W'(drem_sh - {1'b0, dt_r}) : DT_W'(drem_sh);
      dvd_r  <= {dvd_r[DVW-2:0], q_bit};
    end
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_valid_r <= 1'b0;
      prev_mag_r   <= '0;
      peak_mag_r   <= '0;
      peak_rate_r  <= '0;
    end else if (cmd.load_out) begin
      if (sts.is_clear) begin
        prev_valid_r <= 1'b0;
        prev_mag_r   <= '0;
        peak_mag_r   <= '0;
        peak_rate_r  <= '0;
      end else begin
        prev_valid_r <= 1'b1;
        prev_mag_r   <= mag_r;
        if (up_mag) begin
          peak_mag_r <= mag_r;
        end
        if (up_rate) begin
          peak_rate_r <= rate_w;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (sts.is_clear) begin
        out_magnitude          <= '0;
        out_change_rate        <= '0;
        out_peak_magnitude     <= '0;
        out_peak_rate          <= '0;
        out_new_peak_magnitude <= 1'b0;
        out_new_peak_rate      <= 1'b0;
      end else begin
        out_magnitude          <= mag_r;
        out_change_rate        <= rate_w;
        out_peak_magnitude     <= up_mag ? mag_r : peak_mag_r;
        out_peak_rate          <= up_rate ? rate_w : peak_rate_r;
        out_new_peak_magnitude <= up_mag;
        out_new_peak_rate      <= up_rate;
      end
    end
  end

endmodule : xymag_dpath
`default_nettype wire
